[rtl/core/rau_pkg.sv]
// Shared types and constants of the rational arithmetic unit.
// No dependencies; used by every module of the block except rau_checker.
`timescale 1ns / 1ps

package rau_pkg;

    localparam int DEF_WIDTH = 32;   // default internal arithmetic width
    localparam int FIELD_W   = 32;   // width of every fraction field on the ports
    localparam int OP_W      = 3;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_EQ  = 3'd4;

    // start/finish pair between the sequencer and one iterative unit
    typedef struct packed {
        logic start;
    } t_unit_req;

    typedef struct packed {
        logic done;
    } t_unit_rsp;

endpackage

[rtl/core/rational_arithmetic_unit.sv]
// Rational arithmetic unit: top level with the operation sequencer.
// Depends on rau_pkg, rau_mul, rau_gcd and rau_div.
`timescale 1ns / 1ps

// Usage:
//  Input stream (s_axis): tdata carries a_num, a_den, b_num, b_den, tuser the op.
//  Output stream (m_axis): tdata carries res_num, res_den, tuser the is_equal flag.
//  One result per input transfer. The block handles one item at a time:
//  o_s_axis_tready is high only while idle, and drops after a transfer until
//  its result has been taken on m_axis.
//  Compare and unused ops present their result in the cycle after the transfer.
//  Arithmetic ops run the cross products through one shift-add multiplier
//  (two or three products), then a binary gcd (one shift or subtract per
//  cycle), then two exact divisions on one restoring divider. A zero
//  numerator or denominator skips gcd and division. Items do not overlap:
//  the next transfer can be taken in the cycle after the result transfer.
//  Reset (synchronous, active low) returns to idle and drops o_m_axis_tvalid.
//  When the receiver stalls, the result holds on m_axis and no input is taken.
module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [127:0]  i_s_axis_tdata,  // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
    input  logic [2:0]    i_s_axis_tuser,  // op[2:0]
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [63:0]   o_m_axis_tdata,  // res_num[31:0], res_den[63:32]
    output logic [0:0]    o_m_axis_tuser   // is_equal[0]
);
    localparam int FW = rau_pkg::FIELD_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_NORM = 7'b0000100,
        S_GCD  = 7'b0001000,
        S_DIVN = 7'b0010000,
        S_DIVD = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    localparam logic [1:0] STEP_FIRST  = 2'd0;  // a_num * b_den (b_num for multiply)
    localparam logic [1:0] STEP_CROSS  = 2'd1;  // a_den * b_num (negated for subtract), add/sub only
    localparam logic [1:0] STEP_DENOM  = 2'd2;  // a_den * b_den (b_num for divide)

    t_state r_state;
    logic [1:0] r_step;
    logic [rau_pkg::OP_W-1:0] r_op;
    logic [WIDTH-1:0] r_an, r_ad, r_bn, r_bd, r_num, r_den, r_g;
    logic r_eq;
    logic r_mul_go, r_gcd_go, r_div_go;

    rau_pkg::t_unit_req mul_req, gcd_req, div_req;
    rau_pkg::t_unit_rsp mul_rsp, gcd_rsp, div_rsp;
    logic [WIDTH-1:0] mul_a, mul_b, prod, gcd_val, quot, div_x;
    logic [WIDTH-1:0] bn_eff, mag_num, mag_den, flip_num, flip_den, q_signed;
    logic s_acc, m_acc, addsub;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign addsub = (r_op == rau_pkg::OP_ADD) || (r_op == rau_pkg::OP_SUB);

    assign bn_eff = (r_op == rau_pkg::OP_SUB) ? {WIDTH{1'b0}} - r_bn : r_bn;

    always_comb begin
        case (r_step)
            STEP_FIRST: begin
                mul_a = r_an;
                mul_b = (r_op == rau_pkg::OP_MUL) ? r_bn : r_bd;
            end
            STEP_CROSS: begin
                mul_a = r_ad;
                mul_b = bn_eff;
            end
            default: begin
                mul_a = r_ad;
                mul_b = (r_op == rau_pkg::OP_DIV) ? r_bn : r_bd;
            end
        endcase
    end

    assign mag_num  = r_num[WIDTH-1] ? {WIDTH{1'b0}} - r_num : r_num;
    assign mag_den  = r_den[WIDTH-1] ? {WIDTH{1'b0}} - r_den : r_den;
    assign flip_num = r_den[WIDTH-1] ? {WIDTH{1'b0}} - r_num : r_num;
    assign flip_den = r_den[WIDTH-1] ? {WIDTH{1'b0}} - r_den : r_den;

    assign div_x = (r_state == S_DIVD) ? mag_den : mag_num;
    // sign comes back from the part being divided; it is still unchanged here
    assign q_signed = ((r_state == S_DIVD) ? r_den[WIDTH-1] : r_num[WIDTH-1])
                      ? {WIDTH{1'b0}} - quot : quot;

    assign mul_req.start = r_mul_go;
    assign gcd_req.start = r_gcd_go;
    assign div_req.start = r_div_go;

    rau_mul #(.WIDTH(WIDTH)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req),
        .i_a(mul_a), .i_b(mul_b), .o_rsp(mul_rsp), .o_prod(prod)
    );

    rau_gcd #(.WIDTH(WIDTH)) u_gcd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(gcd_req),
        .i_a(mag_num), .i_b(mag_den), .o_rsp(gcd_rsp), .o_gcd(gcd_val)
    );

    rau_div #(.WIDTH(WIDTH)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),
        .i_dividend(div_x), .i_divisor(r_g), .o_rsp(div_rsp), .o_quot(quot)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= STEP_FIRST;
            r_mul_go <= 1'b0;
            r_gcd_go <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_mul_go <= 1'b0;
            r_gcd_go <= 1'b0;
            r_div_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (i_s_axis_tuser inside {rau_pkg::OP_ADD, rau_pkg::OP_SUB,
                                                   rau_pkg::OP_MUL, rau_pkg::OP_DIV}) begin
                            r_state  <= S_MUL;
                            r_step   <= STEP_FIRST;
                            r_mul_go <= 1'b1;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_MUL: begin
                    if (mul_rsp.done) begin
                        case (r_step)
                            STEP_FIRST: begin
                                r_step   <= addsub ? STEP_CROSS : STEP_DENOM;
                                r_mul_go <= 1'b1;
                            end
                            STEP_CROSS: begin
                                r_step   <= STEP_DENOM;
                                r_mul_go <= 1'b1;
                            end
                            default: r_state <= S_NORM;
                        endcase
                    end
                end
                S_NORM: begin
                    if (flip_num != '0 && flip_den != '0) begin
                        r_state  <= S_GCD;
                        r_gcd_go <= 1'b1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_GCD: begin
                    if (gcd_rsp.done) begin
                        r_state  <= S_DIVN;
                        r_div_go <= 1'b1;
                    end
                end
                S_DIVN: begin
                    if (div_rsp.done) begin
                        r_state  <= S_DIVD;
                        r_div_go <= 1'b1;
                    end
                end
                S_DIVD: begin
                    if (div_rsp.done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_acc) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_op  <= i_s_axis_tuser;
                    r_an  <= WIDTH'($signed(i_s_axis_tdata[31:0]));
                    r_ad  <= WIDTH'($signed(i_s_axis_tdata[63:32]));
                    r_bn  <= WIDTH'($signed(i_s_axis_tdata[95:64]));
                    r_bd  <= WIDTH'($signed(i_s_axis_tdata[127:96]));
                    r_num <= '0;
                    r_den <= '0;
                    r_eq  <= (i_s_axis_tuser == rau_pkg::OP_EQ) &&
                             (i_s_axis_tdata[63:0] == i_s_axis_tdata[127:64]);
                end
            end
            S_MUL: begin
                if (mul_rsp.done) begin
                    case (r_step)
                        STEP_FIRST: r_num <= prod;
                        STEP_CROSS: r_num <= r_num + prod;
                        default:    r_den <= prod;
                    endcase
                end
            end
            S_NORM: begin
                r_num <= flip_num;
                r_den <= flip_den;
            end
            S_GCD: begin
                if (gcd_rsp.done) r_g <= gcd_val;
            end
            S_DIVN: begin
                if (div_rsp.done) r_num <= q_signed;
            end
            S_DIVD: begin
                if (div_rsp.done) r_den <= q_signed;
            end
            default: ;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {FW'($signed(r_den)), FW'($signed(r_num))};
    assign o_m_axis_tuser  = r_eq;
endmodule

[rtl/core/rau_mul.sv]
// Shift-add multiplier, one partial product per cycle, low WIDTH bits kept.
// Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_mul #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rau_pkg::t_unit_req  i_req,
    input  logic [WIDTH-1:0]    i_a,
    input  logic [WIDTH-1:0]    i_b,
    output rau_pkg::t_unit_rsp  o_rsp,
    output logic [WIDTH-1:0]    o_prod
);
    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_a, r_b, r_acc;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(WIDTH - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            if (r_b[0]) r_acc <= r_acc + r_a;
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_prod     = r_acc;
endmodule

[rtl/core/rau_gcd.sv]
// Binary gcd of two nonzero unsigned magnitudes, one shift or subtract per cycle.
// Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_gcd #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rau_pkg::t_unit_req  i_req,
    input  logic [WIDTH-1:0]    i_a,
    input  logic [WIDTH-1:0]    i_b,
    output rau_pkg::t_unit_rsp  o_rsp,
    output logic [WIDTH-1:0]    o_gcd
);
    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_u, r_v, r_g;
    logic [CW-1:0]    r_k;
    logic             r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_u == '0 || r_v == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_u <= i_a;
            r_v <= i_b;
            r_k <= '0;
        end else if (r_busy) begin
            if (r_u == '0 || r_v == '0) begin
                r_g <= (r_u | r_v) << r_k;
            end else if (!r_u[0] && !r_v[0]) begin
                // common factor of two
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u >= r_v) begin
                r_u <= r_u - r_v;
            end else begin
                r_v <= r_v - r_u;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_gcd      = r_g;
endmodule

[rtl/core/rau_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_div #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rau_pkg::t_unit_req  i_req,
    input  logic [WIDTH-1:0]    i_dividend,
    input  logic [WIDTH-1:0]    i_divisor,
    output rau_pkg::t_unit_rsp  o_rsp,
    output logic [WIDTH-1:0]    o_quot
);
    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_x, r_rem, r_d;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;
    logic [WIDTH:0]   rem_sh, diff;
    logic             ge;

    assign rem_sh = {r_rem, r_x[WIDTH-1]};
    assign diff   = rem_sh - {1'b0, r_d};
    assign ge     = rem_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(WIDTH - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // quotient bits shift into r_x as the dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
            r_x   <= {r_x[WIDTH-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_quot     = r_x;
endmodule

[rtl/core/rau_checker.sv]
// Port-level checks of the rational arithmetic unit, bound to the top level.
// Depends on rational_arithmetic_unit.
`timescale 1ns / 1ps

module rau_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_s_axis_tvalid,
    input logic          o_s_axis_tready,
    input logic          o_m_axis_tvalid,
    input logic          i_m_axis_tready,
    input logic [63:0]   o_m_axis_tdata,
    input logic [0:0]    o_m_axis_tuser
);
    // one item in flight: ready drops right after an input transfer
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken again before result delivered");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("ready while a result is pending");

    a_eq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == 64'd0))
        else $error("equal flag with nonzero fraction");

    a_ready_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready) |=> (o_s_axis_tready && !o_m_axis_tvalid))
        else $error("not idle after result transfer");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata(o_m_axis_tdata),
    .o_m_axis_tuser(o_m_axis_tuser)
);

[dv/tb_top.sv]
// Testbench for rational_arithmetic_unit: random and directed fraction ops,
// checked against an in-bench predictor. Depends on rau_pkg and the RTL.
`timescale 1ns / 1ps

class fraction_scoreboard;
    logic [63:0] pending_res[$];
    logic        pending_eq[$];
    int          n_mismatch;

    function automatic logic [31:0] mag32(logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    function automatic logic [31:0] gcd32(logic [31:0] a, logic [31:0] b);
        logic [31:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [31:0] exact_div(logic [31:0] x, logic [31:0] g);
        logic [31:0] q;
        q = mag32(x) / g;
        return x[31] ? (32'd0 - q) : q;
    endfunction

    function void note_item(logic [2:0] op, logic [127:0] d);
        logic [31:0] an, ad, bn, bd, n, dn, g;
        logic eq;
        an = d[31:0]; ad = d[63:32]; bn = d[95:64]; bd = d[127:96];
        n = '0; dn = '0; eq = 1'b0;
        case (op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                if (op == rau_pkg::OP_SUB) bn = 32'd0 - bn;
                n = an * bd + ad * bn;
                dn = ad * bd;
            end
            rau_pkg::OP_MUL: begin
                n = an * bn;
                dn = ad * bd;
            end
            rau_pkg::OP_DIV: begin
                n = an * bd;
                dn = ad * bn;
            end
            rau_pkg::OP_EQ: eq = (an == bn) && (ad == bd);
            default: ;
        endcase
        if (op <= rau_pkg::OP_DIV) begin
            if (dn[31]) begin
                n = 32'd0 - n;
                dn = 32'd0 - dn;
            end
            if (n != 0 && dn != 0) begin
                g = gcd32(mag32(n), mag32(dn));
                if (g > 1) begin
                    n = exact_div(n, g);
                    dn = exact_div(dn, g);
                end
            end
        end
        pending_res.push_back({dn, n});
        pending_eq.push_back(eq);
    endfunction

    function void check_result(logic [63:0] res, logic eq);
        logic [63:0] er;
        logic ee;
        if (pending_res.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected result %h eq=%b", res, eq);
            return;
        end
        er = pending_res.pop_front();
        ee = pending_eq.pop_front();
        if (er !== res || ee !== eq) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("mismatch: exp num=%h den=%h eq=%b got num=%h den=%h eq=%b",
                         er[31:0], er[63:32], ee, res[31:0], res[63:32], eq);
        end
    endfunction
endclass

module tb_top;
    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         stim_done = 0;
    int           rx_gap = 0;

    fraction_scoreboard sb = new();

    rational_arithmetic_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // interesting 32-bit values: extremes, small numbers and shared factors
    function automatic logic [31:0] pick_field();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return 32'hffff_ffff;
            4, 5: return $urandom_range(1, 60);
            6: return 32'd0 - $urandom_range(1, 60);
            7: return $urandom_range(1, 60) << $urandom_range(0, 24);
            default: return $urandom;
        endcase
    endfunction

    // tvalid stays up across back-to-back items; dropped only for a gap
    task automatic send_item(logic [2:0] op, logic [127:0] d);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
        sb.note_item(op, d);
    endtask

    initial begin
        logic [31:0] a, b, c, d;
        logic [2:0] op;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        for (int k = 0; k < 8; k++) begin
            // one directed item per op, including unused codes
            send_item(k[2:0], {32'd4, 32'd3, 32'd6, 32'd2});
        end
        send_item(rau_pkg::OP_ADD,
                  {32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff});
        send_item(rau_pkg::OP_MUL, {32'hffff_ffff, 32'h8000_0000, 32'd1, 32'hffff_ffff});
        send_item(rau_pkg::OP_DIV, {32'd5, 32'd0, 32'd7, 32'd3});  // zero divisor numerator
        send_item(rau_pkg::OP_ADD, {32'd5, 32'd0, 32'd7, 32'd0});  // zero numerators
        send_item(rau_pkg::OP_MUL, {32'd5, 32'd9, 32'd7, 32'd0});  // zero numerator
        send_item(rau_pkg::OP_SUB, {32'd3, 32'd2, 32'd3, 32'd2});
        send_item(rau_pkg::OP_EQ,  {32'd3, 32'd2, 32'd3, 32'd2});
        send_item(rau_pkg::OP_EQ,  {32'd3, 32'd2, 32'd3, 32'd3});
        send_item(rau_pkg::OP_DIV, {32'h8000_0000, 32'd1, 32'd1, 32'h8000_0000});
        send_item(rau_pkg::OP_MUL,
                  {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
        for (int i = 0; i < 1750; i++) begin
            a = pick_field(); b = pick_field(); c = pick_field(); d = pick_field();
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            if (op == rau_pkg::OP_EQ && $urandom_range(0, 1)) begin
                c = a;
                if ($urandom_range(0, 2) != 0) d = b;
            end
            send_item(op, {d, c, b, a});
        end
        s_tvalid  <= 0;
        stim_done <= 1;
    end

    // receiver: after each result transfer ready drops for a random gap, or stays high if the gap is zero
    always @(posedge i_clk) begin
        int g;
        g = gap_len();
        if (!i_rst_n) begin
            m_tready <= 0;
            rx_gap   <= 0;
        end else if (m_tready && m_tvalid) begin
            sb.check_result(m_tdata, m_tuser[0]);
            rx_gap   <= g;
            m_tready <= (g == 0);
        end else if (rx_gap > 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= (rx_gap == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        wait (stim_done);
        while (sb.pending_res.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (sb.n_mismatch == 0 && sb.pending_res.size() == 0)
            $display("rational_arithmetic_unit regression: pass");
        else
            $display("rational_arithmetic_unit regression: fail");
        $finish;
    end

    initial begin
        #40000000;
        $display("rational_arithmetic_unit regression: fail");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/rau_pkg.sv
rtl/core/rau_mul.sv
rtl/core/rau_gcd.sv
rtl/core/rau_div.sv
rtl/core/rational_arithmetic_unit.sv
rtl/core/rau_checker.sv
dv/tb_top.sv
